>>> rtl/radix_integer_text_parser_top_defines.svh
// ----------------------------------------------------------------------------
// radix_integer_text_parser_top_defines
// Assertion macros used by the checker file of the integer text parser.
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH
`define RADIX_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define RITP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define RITP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ritp_pkg.sv
// ----------------------------------------------------------------------------
// ritp_pkg
// Types and character constants of the integer text parser.
// ----------------------------------------------------------------------------
package ritp_pkg;

  localparam int BASE_W = 6;
  localparam int END_W  = 12;
  localparam int DIG_W  = 6;

  localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [BASE_W-1:0] B_AUTO      = 6'd0;
  localparam logic [BASE_W-1:0] B_BIN       = 6'd2;
  localparam logic [BASE_W-1:0] B_OCT       = 6'd8;
  localparam logic [BASE_W-1:0] B_DEC       = 6'd10;
  localparam logic [BASE_W-1:0] B_HEX       = 6'd16;
  localparam logic [BASE_W-1:0] B_MAX       = 6'd36;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] UP_OFS   = CH_UA - 8'd10;
  localparam logic [7:0] LO_OFS   = CH_LA - 8'd10;

  // one classified character word
  typedef struct packed {
    logic             ws;
    logic             minus;
    logic             plus;
    logic             zero;
    logic             x_mark;
    logic             b_mark;
    logic             dig_ok;
    logic [DIG_W-1:0] dig;
    logic             last;
  } cls_t;

endpackage

>>> rtl/ritp_front.sv
// ----------------------------------------------------------------------------
// ritp_front
// Character classifier: whitespace, sign, prefix marks and digit value.
// ----------------------------------------------------------------------------
module ritp_front (
  input  logic [7:0]    in_ch,
  input  logic          in_last,
  output ritp_pkg::cls_t cls
);

  logic [7:0] dig_full;
  logic       dig_ok;

  always_comb begin
    dig_ok   = 1'b1;
    dig_full = '0;
    if (in_ch inside {[ritp_pkg::CH_0:ritp_pkg::CH_9]}) begin
      dig_full = in_ch - ritp_pkg::CH_0;
    end else if (in_ch inside {[ritp_pkg::CH_UA:ritp_pkg::CH_UZ]}) begin
      dig_full = in_ch - ritp_pkg::UP_OFS;
    end else if (in_ch inside {[ritp_pkg::CH_LA:ritp_pkg::CH_LZ]}) begin
      dig_full = in_ch - ritp_pkg::LO_OFS;
    end else begin
      dig_ok = 1'b0;
    end
  end

  always_comb begin
    cls.ws     = (in_ch inside {ritp_pkg::CH_SPACE, [ritp_pkg::CH_TAB:ritp_pkg::CH_CR]});
    cls.minus  = (in_ch == ritp_pkg::CH_MINUS);
    cls.plus   = (in_ch == ritp_pkg::CH_PLUS);
    cls.zero   = (in_ch == ritp_pkg::CH_0);
    cls.x_mark = (in_ch inside {ritp_pkg::CH_LX, ritp_pkg::CH_UX});
    cls.b_mark = (in_ch inside {ritp_pkg::CH_LB, ritp_pkg::CH_UB});
    cls.dig_ok = dig_ok;
    cls.dig    = dig_full[ritp_pkg::DIG_W-1:0];
    cls.last   = in_last;
  end

endmodule

>>> rtl/ritp_queue.sv
// ----------------------------------------------------------------------------
// ritp_queue
// Two-entry queue of classified words between classifier and parser core.
// ----------------------------------------------------------------------------
module ritp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ritp_pkg::cls_t push_data,
  output logic           can_push,
  input  logic           pop,
  output logic           head_valid,
  output ritp_pkg::cls_t head_data
);

  ritp_pkg::cls_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign can_push   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];

endmodule

>>> rtl/ritp_back.sv
// ----------------------------------------------------------------------------
// ritp_back
// Parser core: phase tracking, multiply-add accumulate with overflow compare,
// and the result register.
// ----------------------------------------------------------------------------
module ritp_back #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_LEN    = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ritp_pkg::BASE_W-1:0]       cfg_wdata,
  input  logic                              head_valid,
  input  ritp_pkg::cls_t                    head_data,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [VALUE_BITS-1:0]      out_value,
  output logic [ritp_pkg::END_W-1:0]        out_end_offset,
  output logic                              out_range_error
);

  localparam int POS_W = $clog2(MAX_LEN);
  localparam int W     = VALUE_BITS + ritp_pkg::BASE_W;
  localparam int EXT_W = POS_W + ritp_pkg::END_W;
  localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VMAX = ~VMIN;
  localparam logic [POS_W-1:0]      POS_TOP = POS_W'(MAX_LEN - 1);

  typedef enum logic [2:0] {
    PH_WS, PH_START, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE, ST_SEEN, ST_OVER
  } status_t;

  phase_t                        phase_r, phase_nxt;
  status_t                       status_r, status_nxt;
  logic                          neg_r, neg_nxt;
  logic [ritp_pkg::BASE_W-1:0]   base_r, base_nxt;
  logic [ritp_pkg::BASE_W-1:0]   radix_r;
  logic [VALUE_BITS-1:0]         acc_r, acc_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [POS_W-1:0]              endp_r, endp_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]         out_value_r, res_value;
  logic [ritp_pkg::END_W-1:0]    out_end_r;
  logic                          out_err_r;

  logic                          fc;
  logic [ritp_pkg::BASE_W-1:0]   fc_base;
  logic                          dod;
  logic [ritp_pkg::BASE_W-1:0]   dod_base;
  logic                          dig_in_base;
  logic [W-1:0]                  prod;
  logic [W-1:0]                  sum;
  logic [W-1:0]                  limit;
  logic [POS_W-1:0]              end_sel;
  logic [EXT_W-1:0]              end_ext;

  assign pop = head_valid && (!head_data.last || !out_valid_r || out_ready);

  assign pos_nxt = (pos_r < POS_TOP) ? pos_r + POS_W'(1) : pos_r;

  // accumulator * base + digit against the signed limit replaces cutoff/cutlim
  assign prod  = W'(acc_r) * W'(dod_base);
  assign sum   = prod + W'(head_data.dig);
  assign limit = W'(VMAX) + W'(neg_r);

  assign dig_in_base = (dod_base >= ritp_pkg::B_BIN) && (dod_base <= ritp_pkg::B_MAX) &&
                       head_data.dig_ok && (head_data.dig < dod_base);

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    neg_nxt    = neg_r;
    base_nxt   = base_r;
    acc_nxt    = acc_r;
    endp_nxt   = endp_r;
    fc         = 1'b0;
    fc_base    = base_r;
    dod        = 1'b0;
    dod_base   = base_r;

    case (phase_r)
      PH_WS: begin
        base_nxt = radix_r;
        if (head_data.ws) begin
          phase_nxt = PH_WS;
        end else if (head_data.minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_START;
        end else if (head_data.plus) begin
          phase_nxt = PH_START;
        end else begin
          fc      = 1'b1;
          fc_base = radix_r;
        end
      end
      PH_START: begin
        fc = 1'b1;
      end
      PH_ZERO: begin
        if (head_data.x_mark && (base_r inside {ritp_pkg::B_AUTO, ritp_pkg::B_HEX})) begin
          base_nxt  = ritp_pkg::B_HEX;
          phase_nxt = PH_PREFIX;
        end else if (head_data.b_mark &&
                     (base_r inside {ritp_pkg::B_AUTO, ritp_pkg::B_BIN})) begin
          base_nxt  = ritp_pkg::B_BIN;
          phase_nxt = PH_PREFIX;
        end else begin
          dod      = 1'b1;
          dod_base = (base_r == ritp_pkg::B_AUTO) ? ritp_pkg::B_OCT : base_r;
          base_nxt = dod_base;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        dod = 1'b1;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (fc) begin
      // leading zero may open a prefix or an octal number
      if (head_data.zero &&
          (fc_base inside {ritp_pkg::B_AUTO, ritp_pkg::B_HEX, ritp_pkg::B_BIN})) begin
        status_nxt = ST_SEEN;
        acc_nxt    = '0;
        endp_nxt   = pos_nxt;
        phase_nxt  = PH_ZERO;
      end else begin
        dod      = 1'b1;
        dod_base = (fc_base == ritp_pkg::B_AUTO) ? ritp_pkg::B_DEC : fc_base;
        base_nxt = dod_base;
      end
    end

    if (dod) begin
      if (dig_in_base) begin
        if (status_r == ST_OVER || sum > limit) begin
          status_nxt = ST_OVER;
        end else begin
          acc_nxt    = sum[VALUE_BITS-1:0];
          status_nxt = ST_SEEN;
        end
        endp_nxt  = pos_nxt;
        phase_nxt = PH_DIGITS;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_comb begin
    if (status_nxt == ST_OVER) begin
      res_value = neg_nxt ? VMIN : VMAX;
    end else if (neg_nxt) begin
      res_value = -acc_nxt;
    end else begin
      res_value = acc_nxt;
    end
    end_sel = (status_nxt != ST_NONE) ? endp_nxt : '0;
    end_ext = EXT_W'(end_sel);
  end

  // a result taken and a new one loaded in the same cycle keeps valid high
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && head_data.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= ritp_pkg::RADIX_RESET;
      phase_r     <= PH_WS;
      status_r    <= ST_NONE;
      neg_r       <= 1'b0;
      base_r      <= '0;
      acc_r       <= '0;
      pos_r       <= '0;
      endp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (head_data.last) begin
          // result out, parser rearms
          phase_r     <= PH_WS;
          status_r    <= ST_NONE;
          neg_r       <= 1'b0;
          base_r      <= '0;
          acc_r       <= '0;
          pos_r       <= '0;
          endp_r      <= '0;
        end else begin
          phase_r  <= phase_nxt;
          status_r <= status_nxt;
          neg_r    <= neg_nxt;
          base_r   <= base_nxt;
          acc_r    <= acc_nxt;
          pos_r    <= pos_nxt;
          endp_r   <= endp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_data.last) begin
      out_value_r <= res_value;
      out_end_r   <= end_ext[ritp_pkg::END_W-1:0];
      out_err_r   <= (status_nxt == ST_OVER);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_end_offset  = out_end_r;
  assign out_range_error = out_err_r;

endmodule

>>> rtl/radix_integer_text_parser_top.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser_top
// Streaming signed integer parser, one character per word, strtol rules.
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, in_ch, in_last       character words in
//   out      out_valid/out_ready, out_value,         one result per string
//            out_end_offset, out_range_error
//   cfg      cfg_we, cfg_wdata                       radix register write
//
// One character per cycle while the queue has room; the word marked last is
// registered in the queue, then the multiply-add core loads the result
// register and raises valid as it pops that word.
// The two-entry queue lets the input keep flowing while a result waits.
// Synchronous active-low reset; radix returns to 10, no clearing pass.
// A last word stalls in the queue only while a result waits unread.
// ----------------------------------------------------------------------------
module radix_integer_text_parser_top #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_LEN    = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ritp_pkg::BASE_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_ch,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_BITS-1:0]  out_value,
  output logic [ritp_pkg::END_W-1:0]    out_end_offset,
  output logic                          out_range_error
);

  ritp_pkg::cls_t cls;
  ritp_pkg::cls_t head_data;
  logic           head_valid;
  logic           pop;

  ritp_front u_front (
    .in_ch   (in_ch),
    .in_last (in_last),
    .cls     (cls)
  );

  ritp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && in_ready),
    .push_data  (cls),
    .can_push   (in_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ritp_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_end_offset  (out_end_offset),
    .out_range_error (out_range_error)
  );

endmodule

>>> rtl/ritp_checker.sv
// ----------------------------------------------------------------------------
// ritp_checker
// Port-level checks of the integer text parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "radix_integer_text_parser_top_defines.svh"

module ritp_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_BITS-1:0]  out_value,
  input logic [ritp_pkg::END_W-1:0]    out_end_offset,
  input logic                          out_range_error
);

  localparam logic [VALUE_BITS-1:0] SAT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] SAT_MAX = ~SAT_MIN;

  logic [VALUE_BITS+ritp_pkg::END_W:0] out_word;
  logic                                out_stall;
  logic                                sat_value;

  assign out_word  = {out_value, out_end_offset, out_range_error};
  assign out_stall = out_valid && !out_ready;
  assign sat_value = (out_value == SAT_MIN) || (out_value == SAT_MAX);

  // saturated results sit exactly on a signed limit
  `RITP_ASSERT_IMP(a_sat_limit, out_valid && out_range_error, sat_value, "bad saturated value")

  // a waiting result word holds still
  `RITP_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word moved")

  // an offered character word stays offered until taken
  `RITP_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid, "input word dropped")

  // nothing comes out of reset as a result
  `RITP_ASSERT_IMP(a_rst_quiet, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind radix_integer_text_parser_top ritp_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_ritp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value       (out_value),
  .out_end_offset  (out_end_offset),
  .out_range_error (out_range_error)
);
